>>> sv/huf_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies; compile before every other file of the block.
package huf_pkg;

  // Field widths of the item and result channels
  localparam int unsigned OP_W   = 2;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned SYM_W  = 7;
  localparam int unsigned KIND_W = 2;

  // Depth of the queue between front and back (power of two)
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = QAW + 1;

  // Opcodes of an input item
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_BIT   = 2'd1,
    OP_END   = 2'd2
  } op_e;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    RES_SYMBOL  = 2'd0,
    RES_MISSING = 2'd1,
    RES_DROPPED = 2'd2,
    RES_CLEAN   = 2'd3
  } res_e;

  // Work kinds held in the queue
  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_BIT,
    KIND_END
  } kind_e;

  // One node table entry
  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             lp;
    logic             rp;
  } node_t;

  // One queued item
  typedef struct packed {
    kind_e            kind;
    logic             bit_val;
    logic [IDX_W-1:0] idx;
    node_t            node;
  } item_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

>>> sv/huf_if.sv
// Valid/ready channel interfaces for items in and results out.
// Depends on huf_pkg.
interface huf_in_if;
  import huf_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] node_index;
  logic             node_is_leaf;
  logic [SYM_W-1:0] node_symbol;
  logic [IDX_W-1:0] left_child;
  logic [IDX_W-1:0] right_child;
  logic             left_present;
  logic             right_present;
  logic             code_bit;

  modport source (
    output valid, opcode, node_index, node_is_leaf, node_symbol,
           left_child, right_child, left_present, right_present, code_bit,
    input  ready
  );
  modport sink (
    input  valid, opcode, node_index, node_is_leaf, node_symbol,
           left_child, right_child, left_present, right_present, code_bit,
    output ready
  );
endinterface

interface huf_out_if;
  import huf_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [SYM_W-1:0]  decoded_symbol;

  modport source (output valid, result_kind, decoded_symbol, input ready);
  modport sink (input valid, result_kind, decoded_symbol, output ready);
endinterface

>>> sv/huf_front.sv
// Front end: accepts items, classifies them and queues the useful ones.
// Depends on huf_pkg and huf_in_if.
module huf_front #(
  parameter int unsigned NODE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  huf_in_if.sink            item_i,
  input  logic              pop_i,
  output huf_pkg::q_head_t  head_o
);
  import huf_pkg::*;

  item_t            fifo_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             keep, push;
  item_t            new_item;

  // Classify the incoming item; drop unused opcodes and writes past the table
  always_comb begin
    keep              = 1'b0;
    new_item.kind     = KIND_WRITE;
    new_item.bit_val  = item_i.code_bit;
    new_item.idx      = item_i.node_index;
    new_item.node     = '{leaf: item_i.node_is_leaf, sym: item_i.node_symbol,
                          left: item_i.left_child, right: item_i.right_child,
                          lp: item_i.left_present, rp: item_i.right_present};
    unique case (item_i.opcode)
      OP_WRITE: begin
        new_item.kind = KIND_WRITE;
        keep          = 32'(item_i.node_index) < 32'(NODE_DEPTH);
      end
      OP_BIT: begin
        new_item.kind = KIND_BIT;
        keep          = 1'b1;
      end
      OP_END: begin
        new_item.kind = KIND_END;
        keep          = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign item_i.ready = (cnt_q != CNT_W'(QDEPTH));
  assign push         = item_i.valid && item_i.ready && keep;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the queued item
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_item;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = fifo_q[rd_ptr_q];

endmodule

>>> sv/huf_back.sv
// Back end: node table memory, tree walk and result register.
// Depends on huf_pkg and huf_out_if.
module huf_back #(
  parameter int unsigned NODE_DEPTH = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  huf_pkg::q_head_t          head_i,
  output logic                      pop_o,
  input  logic                      cfg_we_i,
  input  logic [huf_pkg::IDX_W-1:0] cfg_wdata_i,
  huf_out_if.source                 result_o
);
  import huf_pkg::*;

  localparam int unsigned AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;

  node_t            mem_q [NODE_DEPTH];
  node_t            rdata_q;
  node_t            root_ent_q, root_ent_d;
  node_t            cur_ent_q, cur_ent_d;
  node_t            node_n;
  logic [IDX_W-1:0] root_q, cur_idx_q, cur_idx_d, child;
  logic             rl_q, rl2_q;
  logic             chk_q, chk_d, walk_q, walk_d;
  logic             out_valid_q, out_valid_d;
  res_e             out_kind_q, out_kind_d;
  logic [SYM_W-1:0] out_sym_q, out_sym_d;
  logic             out_free, can_go, node_ok, walk_eff, root_in;
  logic             pres, child_in, bit_emits, needs_out;
  logic             re, we;
  logic [AW-1:0]    raddr, waddr;
  logic             emit;
  res_e             emit_kind;
  logic [SYM_W-1:0] emit_sym;

  assign out_free = !out_valid_q || result_o.ready;
  assign root_in  = 32'(root_q) < 32'(NODE_DEPTH);

  // Walk control: resolve a child read, then take the next queued item
  always_comb begin
    root_ent_d = root_ent_q;
    cur_ent_d  = cur_ent_q;
    cur_idx_d  = cur_idx_q;
    chk_d      = chk_q;
    walk_d     = walk_q;
    re         = 1'b0;
    raddr      = AW'(root_q);
    we         = 1'b0;
    waddr      = AW'(head_i.item.idx);
    emit       = 1'b0;
    emit_kind  = RES_CLEAN;
    emit_sym   = '0;
    pop_o      = 1'b0;
    can_go     = 1'b0;
    node_n     = walk_q ? cur_ent_q : root_ent_q;
    node_ok    = walk_q || root_in;
    walk_eff   = walk_q;

    priority if (rl_q) begin
      re    = 1'b1;
      raddr = AW'(root_q);
    end else if (rl2_q) begin
      root_ent_d = rdata_q;
    end else if (chk_q) begin
      if (rdata_q.leaf) begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = RES_SYMBOL;
          emit_sym  = rdata_q.sym;
          chk_d     = 1'b0;
          walk_d    = 1'b0;
        end
      end else begin
        chk_d     = 1'b0;
        walk_d    = 1'b1;
        cur_ent_d = rdata_q;
        node_n    = rdata_q;
        node_ok   = 1'b1;
        walk_eff  = 1'b1;
        can_go    = 1'b1;
      end
    end else begin
      can_go = 1'b1;
    end

    // Pick the child for the current bit
    child     = head_i.item.bit_val ? node_n.right : node_n.left;
    pres      = head_i.item.bit_val ? node_n.rp : node_n.lp;
    child_in  = 32'(child) < 32'(NODE_DEPTH);
    bit_emits = !node_ok || node_n.leaf || !pres || !child_in;
    needs_out = (head_i.item.kind == KIND_END) ||
                ((head_i.item.kind == KIND_BIT) && bit_emits);

    if (can_go && head_i.valid && (!needs_out || out_free)) begin
      pop_o = 1'b1;
      unique case (head_i.item.kind)
        KIND_WRITE: begin
          we = 1'b1;
          if (head_i.item.idx == root_q) begin
            root_ent_d = head_i.item.node;
          end
          if (walk_eff && (head_i.item.idx == cur_idx_q)) begin
            cur_ent_d = head_i.item.node;
          end
        end
        KIND_BIT: begin
          walk_d = 1'b0;
          if (!node_ok) begin
            emit      = 1'b1;
            emit_kind = RES_MISSING;
          end else if (node_n.leaf) begin
            emit      = 1'b1;
            emit_kind = RES_SYMBOL;
            emit_sym  = node_n.sym;
          end else if (!pres || !child_in) begin
            emit      = 1'b1;
            emit_kind = RES_MISSING;
          end else begin
            re        = 1'b1;
            raddr     = AW'(child);
            cur_idx_d = child;
            chk_d     = 1'b1;
          end
        end
        KIND_END: begin
          walk_d = 1'b0;
          emit   = 1'b1;
          if (walk_eff) begin
            emit_kind = RES_DROPPED;
          end else begin
            emit_kind = RES_CLEAN;
          end
        end
        default: pop_o = 1'b1;
      endcase
    end
  end

  // Load or drain the result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_sym_d   = out_sym_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = emit_kind;
      out_sym_d   = emit_sym;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q      <= '0;
      rl_q        <= 1'b0;
      rl2_q       <= 1'b0;
      chk_q       <= 1'b0;
      walk_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      rl_q        <= cfg_we_i;
      rl2_q       <= rl_q;
      chk_q       <= chk_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload state
  always_ff @(posedge clk_i) begin
    root_ent_q <= root_ent_d;
    cur_ent_q  <= cur_ent_d;
    cur_idx_q  <= cur_idx_d;
    out_kind_q <= out_kind_d;
    out_sym_q  <= out_sym_d;
  end

  // Node table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= head_i.item.node;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.result_kind    = out_kind_q;
  assign result_o.decoded_symbol = out_sym_q;

endmodule

>>> sv/huffman_tree_decoder.sv
// Huffman tree-walk decoder top level: front queue plus walk back end.
// Depends on huf_pkg, huf_if, huf_front and huf_back.
//
// Usage:
//   item_i carries node writes, code bits and end-of-stream items on a
//   valid/ready handshake; result_o returns symbols, missing-child errors
//   and end reports. cfg_we_i/cfg_wdata_i set the root node index.
//   A result is registered in the output register when the back end takes
//   its item, or after the child read for a bit that reaches a leaf below
//   the root. Throughput: one item per cycle unless stalled; a bit that
//   lands on a leaf child stalls the walk, since the child entry comes
//   from the node table's registered read port and is checked in the
//   following cycle. A root write stalls to reload the cached root entry.
//   Reset empties the four-entry queue, clears the result register, sets
//   the root to 0 and puts the walk at the root; the node table holds
//   nothing valid until written.
//   When result_o stalls, the back end holds at the next item that needs a
//   result and the queue fills; item_i ready drops once four items wait.
module huffman_tree_decoder #(
  parameter int unsigned NODE_DEPTH = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  huf_in_if.sink                    item_i,
  huf_out_if.source                 result_o,
  input  logic                      cfg_we_i,
  input  logic [huf_pkg::IDX_W-1:0] cfg_wdata_i
);
  import huf_pkg::*;

  q_head_t head;
  logic    pop;

  huf_front #(.NODE_DEPTH(NODE_DEPTH)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .pop_i  (pop),
    .head_o (head)
  );

  huf_back #(.NODE_DEPTH(NODE_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (result_o)
  );

endmodule

>>> sv/huf_checker.sv
// Port-level checks for the Huffman decoder, bound to the top level.
// Depends on huf_pkg and huffman_tree_decoder.
module huf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [huf_pkg::OP_W-1:0]   in_opcode_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [huf_pkg::KIND_W-1:0] out_kind_i,
  input logic [huf_pkg::SYM_W-1:0]  out_symbol_i
);
  import huf_pkg::*;

  logic seen_bit_q;

  // Remember whether any code bit was accepted since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_bit_q <= 1'b0;
    end else if (in_valid_i && in_ready_i && (in_opcode_i == OP_BIT)) begin
      seen_bit_q <= 1'b1;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_kind_i) && $stable(out_symbol_i))
    else $error("stalled result changed");

  // Only a symbol result carries a symbol
  a_sym_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != RES_SYMBOL) |-> (out_symbol_i == '0))
    else $error("non-symbol result carries a symbol");

  // Symbols, errors and dropped codes need a code bit first
  a_bit_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != RES_CLEAN) |-> seen_bit_q)
    else $error("walk result without any code bit");

endmodule

bind huffman_tree_decoder huf_checker u_huf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .in_opcode_i  (item_i.opcode),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_kind_i   (result_o.result_kind),
  .out_symbol_i (result_o.decoded_symbol)
);
